>>> hw/rtl/fix_heading_speed_estimator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fix heading/speed estimator
// Implication checks sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FIX_HEADING_SPEED_ESTIMATOR_ASSERT_SVH
`define FIX_HEADING_SPEED_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define FHSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fhse assertion failed");

// next-cycle implication
`define FHSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fhse assertion failed");

`endif

>>> hw/rtl/fhse_pkg.sv
// ----------------------------------------------------------------------------
// fhse_pkg
// Types, register codes and constants of the fix heading/speed estimator.
// ----------------------------------------------------------------------------
package fhse_pkg;

  localparam int POS_BITS  = 24;
  localparam int TIME_BITS = 32;
  localparam int CORD_W    = POS_BITS + 10;   // CORDIC datapath, signed
  localparam int MAG_W     = CORD_W + 16;     // magnitude * inverse gain
  localparam int DIST_W    = CORD_W - 2;      // distance, Q.6
  localparam int MUL_W     = DIST_W + 20;     // distance * 1e6
  localparam int NUM_W     = DIST_W + 21;     // speed dividend
  localparam int DEN_W     = TIME_BITS + 10;  // dt * 1024
  localparam int HEAD_W    = 33;              // error * gain
  localparam int EMA_W     = 34;              // speed blend products
  localparam int ADDR_W    = 4;

  localparam logic [1:0] REG_HEADING_GAIN = 2'd0;
  localparam logic [1:0] REG_SPEED_KEEP   = 2'd1;
  localparam logic [1:0] REG_MIN_INTERVAL = 2'd2;

  localparam logic [15:0] GAIN_RST     = 16'd32768;
  localparam logic [15:0] KEEP_RST     = 16'd45875;
  localparam logic [19:0] MIN_INT_RST  = 20'd1000;
  localparam logic [15:0] INV_CORD_GAIN = 16'd39797;
  localparam logic [19:0] US_PER_SEC    = 20'd1000000;

  typedef struct packed {
    logic signed [POS_BITS-1:0] fix_x;
    logic signed [POS_BITS-1:0] fix_y;
    logic [TIME_BITS-1:0]       fix_time_us;
  } fix_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic [15:0]        speed;
    logic               updated;
  } est_t;

  typedef struct packed {
    logic [15:0] heading_gain;
    logic [15:0] speed_keep;
    logic [19:0] min_interval_us;
  } cfg_t;

  function automatic logic [31:0] atan_entry(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:    r = 32'd536870912;
      4'd1:    r = 32'd316933406;
      4'd2:    r = 32'd167458907;
      4'd3:    r = 32'd85004756;
      4'd4:    r = 32'd42667331;
      4'd5:    r = 32'd21354465;
      4'd6:    r = 32'd10680862;
      4'd7:    r = 32'd5340245;
      4'd8:    r = 32'd2670163;
      4'd9:    r = 32'd1335087;
      4'd10:   r = 32'd667544;
      4'd11:   r = 32'd333772;
      4'd12:   r = 32'd166886;
      4'd13:   r = 32'd83443;
      4'd14:   r = 32'd41722;
      default: r = 32'd20861;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/fhse_regs.sv
// ----------------------------------------------------------------------------
// fhse_regs
// APB register file: heading gain, speed keep weight, minimum interval.
// ----------------------------------------------------------------------------
module fhse_regs import fhse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr;
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heading_gain    <= GAIN_RST;
      cfg.speed_keep      <= KEEP_RST;
      cfg.min_interval_us <= MIN_INT_RST;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_HEADING_GAIN: cfg.heading_gain    <= pwdata[15:0];
        REG_SPEED_KEEP:   cfg.speed_keep      <= pwdata[15:0];
        REG_MIN_INTERVAL: cfg.min_interval_us <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HEADING_GAIN: prdata = {16'd0, cfg.heading_gain};
      REG_SPEED_KEEP:   prdata = {16'd0, cfg.speed_keep};
      REG_MIN_INTERVAL: prdata = {12'd0, cfg.min_interval_us};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

>>> hw/rtl/fhse_cordic.sv
// ----------------------------------------------------------------------------
// fhse_cordic
// Vectoring CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module fhse_cordic import fhse_pkg::*; #(
  parameter int W = 34
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] x0,
  input  logic signed [W-1:0] y0,
  input  logic [31:0]         ang0,
  output logic signed [W-1:0] x,
  output logic [31:0]         ang,
  output logic                done
);

  logic signed [W-1:0] cy;
  logic signed [W-1:0] sx, sy;
  logic [3:0]          step;
  logic                busy;

  assign sx = x >>> step;
  assign sy = cy >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= x0;
        cy   <= y0;
        ang  <= ang0;
        step <= 4'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cy > 0) begin
          x   <= x + sy;
          cy  <= cy - sx;
          ang <= ang + atan_entry(step);
        end else begin
          x   <= x - sy;
          cy  <= cy + sx;
          ang <= ang - atan_entry(step);
        end
        step <= step + 4'd1;
        if (step == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/fhse_mac.sv
// ----------------------------------------------------------------------------
// fhse_mac
// Shift-add multiplier: one multiplier bit per cycle, product modulo 2^OW.
// ----------------------------------------------------------------------------
module fhse_mac #(
  parameter int OW = 34,
  parameter int BW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [OW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [OW-1:0] acc,
  output logic          done
);

  localparam int CNT_W = (BW > 1) ? $clog2(BW) : 1;

  logic [OW-1:0]    mcand;
  logic [BW-1:0]    mplier;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand  <= a;
        mplier <= b;
        acc    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[OW-2:0], 1'b0};
        mplier <= mplier >> 1;
        cnt    <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/fhse_div.sv
// ----------------------------------------------------------------------------
// fhse_div
// Restoring divider, one quotient bit per cycle, saturating at 16 bits.
// ----------------------------------------------------------------------------
module fhse_div #(
  parameter int NW = 53,
  parameter int DW = 42
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [15:0]   quo,
  output logic          done
);

  localparam int HW = NW - 16;
  localparam int MW = (HW > DW) ? HW : DW;

  logic [MW-1:0] hi_ext, den_ext;
  logic          sat;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic [15:0]   low;
  logic [3:0]    cnt;
  logic          busy;

  assign hi_ext  = MW'(num[NW-1:16]);
  assign den_ext = MW'(den);
  assign sat     = hi_ext >= den_ext;
  assign trial   = {rem, low[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          quo  <= 16'hFFFF;
          done <= 1'b1;
        end else begin
          rem  <= DW'(hi_ext);
          low  <= num[15:0];
          quo  <= 16'd0;
          cnt  <= 4'd0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= DW'(trial - {1'b0, den});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          quo <= {quo[14:0], 1'b0};
        end
        low <= {low[14:0], 1'b0};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/fix_heading_speed_estimator.sv
// ----------------------------------------------------------------------------
// fix_heading_speed_estimator
// Smoothed heading and speed from timestamped position fixes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, payload fix): one position fix per item.
//   Output channel (out_valid/out_ready, payload est): one result per fix,
//   heading (binary angle), speed (Q8.8 m/s) and the updated flag.
//   APB port: heading_gain at 0x0, speed_keep at 0x4, min_interval_us at 0x8.
// Sequencing:
//   One fix at a time. A fix that only restarts tracking (first fix or
//   too-short interval) goes from acceptance to the done state and then
//   into the output register. An updating fix runs 16 CORDIC steps, 16
//   bit-serial steps for distance and heading gain, 20 for distance * 1e6,
//   16 divider steps (skipped when the raw speed saturates) and 17 for the
//   speed blend, each unit started when the one before it is done. The
//   serial units handle one bit per cycle. The next fix can be taken in the
//   cycle after the result is loaded.
// Reset:
//   Clears the stored fix, heading and speed; registers go to their defaults.
// Stall:
//   The result sits in an output register; a finished result waits in the
//   last state until the output register frees up.
// ----------------------------------------------------------------------------
`include "fix_heading_speed_estimator_assert.svh"

module fix_heading_speed_estimator import fhse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fix_t              fix,
  output logic              out_valid,
  input  logic              out_ready,
  output est_t              est,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CORD = 3'd1;
  localparam logic [2:0] ST_MAG  = 3'd2;
  localparam logic [2:0] ST_NUM  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_EMA  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  cfg_t cfg;

  logic [2:0]                 state;
  logic signed [POS_BITS-1:0] last_x, last_y;
  logic [TIME_BITS-1:0]       last_time;
  logic                       have_fix;
  logic [15:0]                heading_state, speed_state;
  logic [TIME_BITS-1:0]       dt;
  logic                       zero_disp;
  logic                       upd;

  // accept-time arithmetic
  logic                       accept;
  logic [TIME_BITS-1:0]       dt_c;
  logic                       go;
  logic signed [POS_BITS:0]   dx, dy;
  logic signed [CORD_W-1:0]   cx0, cy0, x0, y0;
  logic [31:0]                ang0;

  // serial units
  logic                       cord_start, cord_done;
  logic signed [CORD_W-1:0]   cord_x;
  logic [31:0]                cord_ang;
  logic                       mag_start, mag_done, head_done;
  logic [MAG_W-1:0]           mag_a, mag_acc, mag_sum;
  logic [HEAD_W-1:0]          head_a, head_acc, head_sum;
  logic                       num_start, num_done;
  logic [MUL_W-1:0]           num_acc;
  logic [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  logic                       div_start, div_done;
  logic [15:0]                quo;
  logic                       ema_start, ema_done, ema_b_done;
  logic [EMA_W-1:0]           ema_acc_a, ema_acc_b, ema_sum;
  logic [16:0]                new_weight;
  logic [31:0]                ang_round;
  logic [15:0]                raw, err;
  logic [DIST_W-1:0]          dist_q;

  fhse_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // update only with a stored fix and enough elapsed time
  assign dt_c = fix.fix_time_us - last_time;
  assign go   = have_fix && (dt_c > TIME_BITS'(cfg.min_interval_us));
  assign dx   = {fix.fix_x[POS_BITS-1], fix.fix_x} - {last_x[POS_BITS-1], last_x};
  assign dy   = {fix.fix_y[POS_BITS-1], fix.fix_y} - {last_y[POS_BITS-1], last_y};
  assign cx0  = CORD_W'(dx) <<< 6;
  assign cy0  = CORD_W'(dy) <<< 6;

  // pre-rotate into the right half plane
  always_comb begin
    if (dx < 0) begin
      x0   = -cx0;
      y0   = -cy0;
      ang0 = 32'h8000_0000;
    end else begin
      x0   = cx0;
      y0   = cy0;
      ang0 = 32'd0;
    end
  end

  assign cord_start = accept && go;

  fhse_cordic #(.W(CORD_W)) u_cordic (
    .clk, .rst, .start(cord_start), .x0, .y0, .ang0,
    .x(cord_x), .ang(cord_ang), .done(cord_done)
  );

  // raw heading and wrapped error, ready when the CORDIC finishes
  assign ang_round = cord_ang + 32'h0000_8000;
  assign raw       = zero_disp ? 16'd0 : ang_round[31:16];
  assign err       = raw - heading_state;

  assign mag_start = cord_done;
  assign mag_a     = (zero_disp || cord_x[CORD_W-1]) ? '0 : MAG_W'(cord_x);
  assign head_a    = {{(HEAD_W-16){err[15]}}, err};

  fhse_mac #(.OW(MAG_W), .BW(16)) u_mag (
    .clk, .rst, .start(mag_start), .a(mag_a), .b(INV_CORD_GAIN),
    .acc(mag_acc), .done(mag_done)
  );

  fhse_mac #(.OW(HEAD_W), .BW(16)) u_head (
    .clk, .rst, .start(mag_start), .a(head_a), .b(cfg.heading_gain),
    .acc(head_acc), .done(head_done)
  );

  assign mag_sum  = mag_acc + MAG_W'(32768);
  assign dist_q   = mag_sum[16 +: DIST_W];
  assign head_sum = head_acc + HEAD_W'(32768);

  assign num_start = mag_done;

  fhse_mac #(.OW(MUL_W), .BW(20)) u_num (
    .clk, .rst, .start(num_start), .a(MUL_W'(dist_q)), .b(US_PER_SEC),
    .acc(num_acc), .done(num_done)
  );

  // dividend = dist * 1e6 + dt * 512 (rounding), divisor = dt * 1024
  assign div_num   = NUM_W'(num_acc) + NUM_W'({dt, 9'd0});
  assign div_den   = {dt, 10'd0};
  assign div_start = num_done;

  fhse_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .quo, .done(div_done)
  );

  assign ema_start  = div_done;
  assign new_weight = 17'h1_0000 - {1'b0, cfg.speed_keep};

  fhse_mac #(.OW(EMA_W), .BW(17)) u_ema_new (
    .clk, .rst, .start(ema_start), .a(EMA_W'(quo)), .b(new_weight),
    .acc(ema_acc_a), .done(ema_done)
  );

  fhse_mac #(.OW(EMA_W), .BW(17)) u_ema_old (
    .clk, .rst, .start(ema_start), .a(EMA_W'(speed_state)),
    .b({1'b0, cfg.speed_keep}), .acc(ema_acc_b), .done(ema_b_done)
  );

  assign ema_sum = ema_acc_a + ema_acc_b + EMA_W'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      have_fix      <= 1'b0;
      last_x        <= '0;
      last_y        <= '0;
      last_time     <= '0;
      heading_state <= 16'd0;
      speed_state   <= 16'd0;
      out_valid     <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_x    <= fix.fix_x;
            last_y    <= fix.fix_y;
            last_time <= fix.fix_time_us;
            dt        <= dt_c;
            zero_disp <= (dx == 0) && (dy == 0);
            if (go) begin
              upd   <= 1'b1;
              state <= ST_CORD;
            end else begin
              upd         <= 1'b0;
              speed_state <= 16'd0;
              have_fix    <= 1'b1;
              state       <= ST_DONE;
            end
          end
        end
        ST_CORD: if (cord_done) state <= ST_MAG;
        ST_MAG: begin
          if (mag_done) begin
            heading_state <= heading_state + head_sum[31:16];
            state         <= ST_NUM;
          end
        end
        ST_NUM: if (num_done) state <= ST_DIV;
        ST_DIV: if (div_done) state <= ST_EMA;
        ST_EMA: begin
          if (ema_done) begin
            speed_state <= ema_sum[31:16];
            state       <= ST_DONE;
          end
        end
        ST_DONE: if (!out_valid || out_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      est.heading <= heading_state;
      est.speed   <= speed_state;
      est.updated <= upd;
    end
  end

  `FHSE_ASSERT_NXT(a_busy_after_accept, accept, state != ST_IDLE)
  `FHSE_ASSERT_IMP(a_cordic_in_phase, cord_done, state == ST_CORD)
  `FHSE_ASSERT_IMP(a_head_with_mag, mag_done, head_done && state == ST_MAG)
  `FHSE_ASSERT_IMP(a_div_in_phase, div_done, state == ST_DIV)
  `FHSE_ASSERT_IMP(a_ema_pair, ema_done, ema_b_done && state == ST_EMA)
  `FHSE_ASSERT_IMP(a_update_needs_fix, out_valid && est.updated, have_fix)

endmodule

>>> verif/tb_fix_heading_speed_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fix_heading_speed_estimator
// Streams position fixes into the estimator under bursty input and a stalling
// output, predicts each heading/speed result in the bench and checks it field
// by field. Register settings change between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_fix_heading_speed_estimator;
  import fhse_pkg::*;

  localparam int N_RANDOM    = 1500;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 200;   // comfortably above the time of one update

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  fix_t              fix;
  logic              out_valid;
  logic              out_ready;
  est_t              est;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  fix_heading_speed_estimator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .fix(fix),
    .out_valid(out_valid), .out_ready(out_ready), .est(est),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // CORDIC angle table, 32-bit binary angle
  bit [31:0] atan_lut [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  // bench copy of the register file
  bit [15:0] cfg_gain = GAIN_RST;
  bit [15:0] cfg_keep = KEEP_RST;
  bit [19:0] cfg_min  = MIN_INT_RST;

  // bench copy of the tracking state
  logic signed [POS_BITS-1:0] prev_x;
  logic signed [POS_BITS-1:0] prev_y;
  bit [TIME_BITS-1:0]         prev_time;
  bit                         have_prev;
  bit [15:0]                  heading_st;
  bit [15:0]                  speed_st;

  fix_t pending_fixes[$];
  est_t expected_est[$];

  int  n_sent, n_checked, n_updates, n_errors, cycles;
  int  burst_left, gap_left;
  bit  hold_input;
  int  stall_mode, stall_timer;

  // generator state: keeps most fixes on a plausible track
  logic signed [POS_BITS-1:0] gen_x, gen_y;
  bit [31:0]                  gen_time;

  // Estimator prediction; updates the bench state for one accepted fix.
  function automatic est_t predict_estimate(fix_t f);
    bit [31:0]       dt;
    longint          dx, dy, cx, cy, sx, sy, err, delta;
    bit [31:0]       ang;
    bit [15:0]       raw, e16;
    longint unsigned dist_q, sp, acc, den;
    bit              upd;
    est_t            r;
    upd = 0;
    dt  = f.fix_time_us - prev_time;
    if (have_prev && dt > 32'(cfg_min)) begin
      dx     = longint'(f.fix_x) - longint'(prev_x);
      dy     = longint'(f.fix_y) - longint'(prev_y);
      raw    = '0;
      dist_q = 0;
      if (dx != 0 || dy != 0) begin
        cx  = dx * 64;
        cy  = dy * 64;
        ang = '0;
        if (cx < 0) begin
          // left half plane: rotate by half a turn first
          cx  = -cx;
          cy  = -cy;
          ang = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
          sx = cx >>> i;
          sy = cy >>> i;
          if (cy > 0) begin
            cx  = cx + sy;
            cy  = cy - sx;
            ang = ang + atan_lut[i];
          end else begin
            cx  = cx - sy;
            cy  = cy + sx;
            ang = ang - atan_lut[i];
          end
        end
        ang  = ang + 32'h8000;
        raw  = ang[31:16];
        if (cx < 0) cx = 0;
        dist_q = (longint'(cx) * 64'd39797 + 64'd32768) >> 16;
      end
      e16   = raw - heading_st;
      err   = e16[15] ? longint'(e16) - 65536 : longint'(e16);
      delta = (err * longint'(cfg_gain) + 32768) >>> 16;
      heading_st = heading_st + delta[15:0];
      den = 64'(dt) * 1024;
      sp  = (dist_q * 64'd1000000 + 64'(dt) * 512) / den;
      if (sp > 65535) sp = 65535;
      acc = 64'(cfg_keep) * 64'(speed_st) + (64'd65536 - 64'(cfg_keep)) * sp + 64'd32768;
      speed_st = acc[31:16];
      upd = 1;
    end else begin
      speed_st  = '0;
      have_prev = 1;
    end
    prev_x    = f.fix_x;
    prev_y    = f.fix_y;
    prev_time = f.fix_time_us;
    r.heading = heading_st;
    r.speed   = speed_st;
    r.updated = upd;
    return r;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Input driver: bursts of items with random gaps; the payload only changes
  // once the current item has been taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_est.push_back(predict_estimate(fix));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_fixes.size() > 0 && !hold_input) begin
          fix      <= pending_fixes.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            // gaps of zero keep long back-to-back stretches
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 150);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: the stall pattern switches mode whenever its timer runs out;
  // mode 0 never stalls, higher modes accept more often.
  always @(posedge clk) begin
    if (rst) begin
      out_ready   <= 1'b0;
      stall_mode  <= 0;
      stall_timer <= 0;
    end else begin
      if (stall_timer == 0) begin
        stall_mode  <= $urandom_range(0, 7);
        stall_timer <= $urandom_range(50, 400);
      end else begin
        stall_timer <= stall_timer - 1;
      end
      out_ready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(1, 8) <= stall_mode);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    est_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_est.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected result heading=%0d speed=%0d updated=%0b",
                   est.heading, est.speed, est.updated);
      end else begin
        want = expected_est.pop_front();
        n_checked++;
        if (want.updated) n_updates++;
        if (est.heading !== want.heading || est.speed !== want.speed ||
            est.updated !== want.updated) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d exp h=%0d s=%0d u=%0b got h=%0d s=%0d u=%0b",
                     n_checked, want.heading, want.speed, want.updated,
                     est.heading, est.speed, est.updated);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_est.size());
      $display("tb_fix_heading_speed_estimator failed");
      $finish;
    end
  end

  // Wait for the block to drain: everything sent, everything checked.
  task automatic wait_idle();
    while (pending_fixes.size() > 0 || in_valid || expected_est.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // APB write: setup then access phase; pready is always high.
  task automatic reg_write(input int idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HEADING_GAIN: cfg_gain = val[15:0];
      REG_SPEED_KEEP:   cfg_keep = val[15:0];
      REG_MIN_INTERVAL: cfg_min  = val[19:0];
      default: ;  // unmapped address, write ignored
    endcase
  endtask

  // Queue a fix and track it in the generator.
  task automatic add_fix(input logic signed [POS_BITS-1:0] x,
                         input logic signed [POS_BITS-1:0] y, input bit [31:0] t);
    fix_t f;
    f.fix_x       = x;
    f.fix_y       = y;
    f.fix_time_us = t;
    pending_fixes.push_back(f);
    gen_x    = x;
    gen_y    = y;
    gen_time = t;
  endtask

  // Random fix: mostly a plausible step along a track, the rest noise.
  task automatic add_random_fix();
    int  sel;
    bit [31:0] step;
    logic signed [POS_BITS-1:0] x, y;
    sel = $urandom_range(0, 99);
    if (sel < 80)
      step = 32'(cfg_min) + $urandom_range(1, 200000);
    else if (sel < 88)
      step = $urandom_range(0, 32'(cfg_min) + 1);        // around the threshold
    else
      step = $urandom();                                  // anything, wraps too
    if (sel < 70) begin
      x = gen_x + POS_BITS'($signed($urandom_range(0, 8191)) - 4096);
      y = gen_y + POS_BITS'($signed($urandom_range(0, 8191)) - 4096);
    end else if (sel < 80 || sel >= 95) begin
      x = POS_BITS'($urandom());
      y = POS_BITS'($urandom());
    end else begin
      // large jumps, which can saturate speed
      x = gen_x + POS_BITS'($signed($urandom_range(0, 2000000)) - 1000000);
      y = gen_y + POS_BITS'($signed($urandom_range(0, 2000000)) - 1000000);
    end
    add_fix(x, y, gen_time + step);
  endtask

  localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    fix        = '0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    hold_input = 1'b0;
    prev_x = '0; prev_y = '0; prev_time = '0; have_prev = 0;
    heading_st = '0; speed_st = '0;
    gen_x = '0; gen_y = '0; gen_time = '0;
    n_sent = 0; n_checked = 0; n_updates = 0; n_errors = 0; cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, default registers.
    add_fix(24'sd0, 24'sd0, 32'd5000);                 // first fix: restart only
    add_fix(24'sd4096, 24'sd0, 32'd6000);              // dt equal to minimum: no update
    add_fix(24'sd8192, 24'sd0, 32'd7001);              // just over minimum
    add_fix(24'sd8192, 24'sd0, 32'd9000);              // zero displacement
    add_fix(24'sd8192, 24'sd8192, 32'd20000);          // due north
    add_fix(-24'sd8192, 24'sd8192, 32'd40000);         // due west (left half plane)
    add_fix(-24'sd8192, -24'sd8192, 32'd60000);        // due south
    add_fix(PMAX, PMAX, 32'd80000);                    // extremes
    add_fix(PMIN, PMIN, 32'd100000);
    add_fix(PMAX, PMIN, 32'd101001);                   // huge step, speed saturates
    add_fix(PMIN, PMIN, 32'd101500);                   // short interval
    add_fix(PMIN, PMIN, 32'hFFFF_F000);                // long gap
    add_fix(PMIN + 24'sd100, PMIN, 32'h0000_1000);     // time wraps
    add_fix(PMIN + 24'sd100, PMIN, 32'h0000_1000);     // dt zero
    wait_idle();

    // Half-turn heading error: heading near zero, then move straight west.
    reg_write(REG_HEADING_GAIN, 32'hFFFF_0000);        // masked to zero gain
    reg_write(REG_SPEED_KEEP, 32'd0);
    reg_write(REG_MIN_INTERVAL, 32'hFFF0_0000);        // masked to zero
    reg_write(3, 32'h1234_5678);                       // unmapped, ignored
    add_fix(24'sd0, 24'sd0, 32'd1000);
    add_fix(24'sd4096, 24'sd0, 32'd1001);              // heading unchanged (gain 0)
    wait_idle();
    reg_write(REG_HEADING_GAIN, 32'd65535);
    add_fix(-24'sd4096, 24'sd0, 32'd3000);             // error of half a turn
    add_fix(-24'sd4096, 24'sd4096, 32'd5000);
    add_fix(24'sd0, 24'sd0, 32'd6000);
    wait_idle();

    // Random phases across several register settings.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          reg_write(REG_HEADING_GAIN, 32'd32768);
          reg_write(REG_SPEED_KEEP, 32'd45875);
          reg_write(REG_MIN_INTERVAL, 32'd1000);
        end
        1: begin
          reg_write(REG_HEADING_GAIN, 32'd0);
          reg_write(REG_SPEED_KEEP, 32'd0);
          reg_write(REG_MIN_INTERVAL, 32'd0);
        end
        2: begin
          reg_write(REG_HEADING_GAIN, 32'd65535);
          reg_write(REG_SPEED_KEEP, 32'd65535);
          reg_write(REG_MIN_INTERVAL, 32'd1000000);
        end
        default: begin
          reg_write(REG_HEADING_GAIN, $urandom());
          reg_write(REG_SPEED_KEEP, $urandom());
          reg_write(REG_MIN_INTERVAL, $urandom_range(0, 50000));
        end
      endcase
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        add_random_fix();
        // once in the middle, hold the input until the output side drains
        if (ph == 2 && k == 100) begin
          hold_input = 1'b1;
          while (pending_fixes.size() > 0 && (in_valid || expected_est.size() > 0))
            @(posedge clk);
          wait (expected_est.size() == 0 && !in_valid);
          @(posedge clk);
          hold_input = 1'b0;
        end
      end
      wait_idle();
    end

    $display("%0d fixes sent, %0d results checked, %0d of them updates",
             n_sent, n_checked, n_updates);
    $display("covered first fix, short intervals, zero moves, time wrap, extremes");
    if (n_errors == 0 && expected_est.size() == 0) begin
      $display("tb_fix_heading_speed_estimator passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb_fix_heading_speed_estimator failed");
    end
    $finish;
  end

endmodule
